@@ rtl/wnp_pkg.sv @@
// Shared types and constants for the weighted neighbor prediction decoder.
// No dependencies; every file in this folder but wnp_ram imports it.
package wnp_pkg;

    // Field and register widths.
    localparam int PIX_W      = 32;
    localparam int WEIGHT_W   = 16;
    localparam int SIZE_W     = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed-point format of the weights.
    localparam int FRAC_BITS = 8;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

    // Largest block height the row counter supports.
    localparam int HEIGHT_LIMIT = 4096;

    // Default line store depth.
    localparam int MAX_WIDTH_DEFAULT = 4096;

    // Reset values of the configuration registers.
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_WEST_RESET      = 16'sd256;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_NORTH_RESET     = 16'sd256;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_NORTHWEST_RESET = -16'sd256;
    localparam logic [SIZE_W-1:0]          BLOCK_WIDTH_RESET      = 13'd64;
    localparam logic [SIZE_W-1:0]          BLOCK_HEIGHT_RESET     = 13'd64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_WEST      = 3'd0,
        REG_WEIGHT_NORTH     = 3'd1,
        REG_WEIGHT_NORTHWEST = 3'd2,
        REG_BLOCK_WIDTH      = 3'd3,
        REG_BLOCK_HEIGHT     = 3'd4
    } cfg_index_t;

    // Which predictor a pixel uses, set by its place in the block.
    typedef enum logic [1:0] {
        PRED_ZERO     = 2'd0,
        PRED_WEST     = 2'd1,
        PRED_NORTH    = 2'd2,
        PRED_WEIGHTED = 2'd3
    } pred_mode_t;

    // Position information that travels with each pixel.
    typedef struct packed {
        pred_mode_t mode;
        logic       last;
    } pos_info_t;

endpackage

@@ rtl/wnp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used as the line store of the decoder.
module wnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; a read at a written address returns the old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/wnp_position.sv @@
// Raster position tracker: column and row counters and the per-pixel mode.
// Depends on wnp_pkg.
module wnp_position #(
    parameter int MAX_WIDTH = wnp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [wnp_pkg::SIZE_W-1:0]    block_width,
    input  logic [wnp_pkg::SIZE_W-1:0]    block_height,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output wnp_pkg::pos_info_t            info
);

    import wnp_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int EXT_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
    localparam int HGT_W = ROW_W + 1;

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [EXT_W-1:0] col_plus;
    logic [HGT_W-1:0] row_plus;
    logic             row_end;
    logic             block_end;

    // End of row and end of block. A size of zero behaves as one, and sizes
    // above the store depth or the height limit are capped there.
    always_comb
    begin
        col_plus  = EXT_W'(col_reg) + EXT_W'(1);
        row_plus  = HGT_W'(row_reg) + HGT_W'(1);
        row_end   = (col_plus >= EXT_W'(MAX_WIDTH)) ||
                    (col_plus >= EXT_W'(block_width));
        block_end = row_end && ((row_plus >= HGT_W'(HEIGHT_LIMIT)) ||
                                (row_plus >= HGT_W'(block_height)));
    end

    // Predictor choice for the pixel at the current position.
    always_comb
    begin
        info.last = block_end;
        priority if (col_reg == '0 && row_reg == '0)
        begin
            info.mode = PRED_ZERO;
        end
        else if (row_reg == '0)
        begin
            info.mode = PRED_WEST;
        end
        else if (col_reg == '0)
        begin
            info.mode = PRED_NORTH;
        end
        else
        begin
            info.mode = PRED_WEIGHTED;
        end
    end

    // Counter update for the next pixel.
    always_comb
    begin
        priority if (block_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_plus[ROW_W-1:0];
        end
        else
        begin
            col_next = col_plus[CNT_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;

    // The column never leaves the line store.
    assert property (@(posedge clk) disable iff (!rst_n)
        EXT_W'(col_reg) < EXT_W'(MAX_WIDTH))
        else $error("column counter beyond line store depth");

    // After the last pixel of a block the position is back at the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && info.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not restarted after end of block");

    // The counters only move when a pixel is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position moved without a pixel");

endmodule

@@ rtl/wnp_predict.sv @@
// Compute stage: input register, predictor and residual add, result register.
// Depends on wnp_pkg; reads and writes the line store through its ports.
module wnp_predict #(
    parameter int MAX_WIDTH = wnp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Residual channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [wnp_pkg::PIX_W-1:0]   residual,
    input  wnp_pkg::pos_info_t                 info,
    input  logic [$clog2(MAX_WIDTH)-1:0]       col,
    output logic                               accept,
    // Weights.
    input  logic signed [wnp_pkg::WEIGHT_W-1:0] weight_west,
    input  logic signed [wnp_pkg::WEIGHT_W-1:0] weight_north,
    input  logic signed [wnp_pkg::WEIGHT_W-1:0] weight_northwest,
    // Line store.
    input  logic [wnp_pkg::PIX_W-1:0]          rd_data,
    output logic                               wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
    output logic [wnp_pkg::PIX_W-1:0]          wr_data,
    // Pixel channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [wnp_pkg::PIX_W-1:0]   pixel_value,
    output logic                               last_of_block
);

    import wnp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int PROD_W = WEIGHT_W + PIX_W;
    localparam int SUM_W  = PROD_W + 2;

    // Stage registers.
    logic                    s_valid_reg;
    logic signed [PIX_W-1:0] residual_reg;
    pos_info_t               info_reg;
    logic [CNT_W-1:0]        addr_reg;
    logic                    byp_hit_reg;
    logic [PIX_W-1:0]        byp_data_reg;

    // Neighbor state.
    logic signed [PIX_W-1:0] west_reg;
    logic signed [PIX_W-1:0] nw_reg;

    // Result register.
    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] pixel_reg;
    logic                    last_reg;

    logic                    s_adv;
    logic signed [PIX_W-1:0] above;
    logic signed [PROD_W-1:0] prod_w;
    logic signed [PROD_W-1:0] prod_n;
    logic signed [PROD_W-1:0] prod_nw;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        sum_adj;
    logic [PIX_W-1:0]        pred;
    logic [PIX_W-1:0]        pix;

    // Handshake: the stage moves on whenever the result register is free
    // or drained in the same cycle, so a new beat can enter every cycle.
    assign s_adv    = s_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || s_adv;
    assign accept   = in_valid && in_ready;

    // The row above comes from the store, or from the pixel written at the
    // very edge the store was read.
    assign above = byp_hit_reg ? byp_data_reg : rd_data;

    // Weighted prediction, divided by 256 with truncation toward zero.
    always_comb
    begin
        prod_w  = weight_west * west_reg;
        prod_n  = weight_north * above;
        prod_nw = weight_northwest * nw_reg;
        sum     = {{2{prod_w[PROD_W-1]}}, prod_w} +
                  {{2{prod_n[PROD_W-1]}}, prod_n} +
                  {{2{prod_nw[PROD_W-1]}}, prod_nw};
        sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(FRAC_MASK) : SUM_W'(0));
    end

    // Predictor selection and reconstruction.
    always_comb
    begin
        unique case (info_reg.mode)
            PRED_ZERO:     pred = '0;
            PRED_WEST:     pred = west_reg;
            PRED_NORTH:    pred = above;
            PRED_WEIGHTED: pred = sum_adj[FRAC_BITS+PIX_W-1:FRAC_BITS];
        endcase
        pix = pred + residual_reg;
    end

    // Write the rebuilt pixel back to the line store as it leaves the stage.
    assign wr_en   = s_adv;
    assign wr_addr = addr_reg;
    assign wr_data = pix;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            s_valid_reg <= 1'b1;
            byp_hit_reg <= s_adv && (addr_reg == col);
        end
        else if (s_adv)
        begin
            s_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            residual_reg <= residual;
            info_reg     <= info;
            addr_reg     <= col;
            byp_data_reg <= pix;
        end
    end

    // Neighbor pixels follow every pixel that leaves the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            west_reg <= '0;
            nw_reg   <= '0;
        end
        else if (s_adv)
        begin
            west_reg <= pix;
            nw_reg   <= above;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s_adv)
        begin
            pixel_reg <= pix;
            last_reg  <= info_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = pixel_reg;
    assign last_of_block = last_reg;

    // A full stage behind a stalled result register takes no new beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("beat accepted while the stage is blocked");

    // A pixel leaving the stage always shows up in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_adv |=> (out_valid_reg && pixel_reg == $past(pix)))
        else $error("stage result not captured");

    // The store bypass only applies to a beat that entered as another left.
    assert property (@(posedge clk) disable iff (!rst_n)
        byp_hit_reg |-> s_valid_reg)
        else $error("store bypass set without a pixel in the stage");

endmodule

@@ rtl/weighted_neighbor_prediction_decode_core.sv @@
// Top level of the weighted neighbor prediction decoder.
// Depends on wnp_pkg, wnp_ram, wnp_position and wnp_predict.
//
// Usage:
//   Residuals enter in raster order on the residual channel, one beat per
//   pixel. Rebuilt pixels leave on the pixel channel, one beat per residual,
//   with last_of_block set on the final pixel of each block.
//   The configuration channel writes the three weights and the block size;
//   it is always ready. The user must write only while no pixel is in
//   flight; the core does not enforce it.
// Pipeline and throughput:
//   A residual waits in the stage register, its pixel in the result one.
//   One beat per cycle while the receiver keeps up, set by the west-pixel
//   loop: weighted sum, divide by 256 and residual add, all combinational.
// Reset:
//   Weights and sizes return to their defaults, the position returns to
//   the first pixel of a block and the neighbor pixels clear to zero. The
//   line store is not cleared; no pixel uses an entry before it is written.
// Stalls:
//   When the pixel receiver holds off, one pixel waits in the result
//   register and one more in the compute stage; then residual_ready drops.
module weighted_neighbor_prediction_decode_core #(
    parameter int MAX_WIDTH = wnp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wnp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wnp_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Residual channel.
    input  logic                                residual_valid,
    output logic                                residual_ready,
    input  logic signed [wnp_pkg::PIX_W-1:0]    residual,
    // Pixel channel.
    output logic                                pixel_valid,
    input  logic                                pixel_ready,
    output logic signed [wnp_pkg::PIX_W-1:0]    pixel_value,
    output logic                                last_of_block
);

    import wnp_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic signed [WEIGHT_W-1:0] weight_west_reg;
    logic signed [WEIGHT_W-1:0] weight_north_reg;
    logic signed [WEIGHT_W-1:0] weight_northwest_reg;
    logic [SIZE_W-1:0]          block_width_reg;
    logic [SIZE_W-1:0]          block_height_reg;

    logic             accept;
    logic [CNT_W-1:0] col;
    pos_info_t        info;
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic [PIX_W-1:0] rd_data;

    // Configuration writes; indexes past the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_west_reg      <= WEIGHT_WEST_RESET;
            weight_north_reg     <= WEIGHT_NORTH_RESET;
            weight_northwest_reg <= WEIGHT_NORTHWEST_RESET;
            block_width_reg      <= BLOCK_WIDTH_RESET;
            block_height_reg     <= BLOCK_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_WEIGHT_WEST:      weight_west_reg      <= cfg_data;
                REG_WEIGHT_NORTH:     weight_north_reg     <= cfg_data;
                REG_WEIGHT_NORTHWEST: weight_northwest_reg <= cfg_data;
                REG_BLOCK_WIDTH:      block_width_reg      <= cfg_data[SIZE_W-1:0];
                REG_BLOCK_HEIGHT:     block_height_reg     <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Raster position of the next residual.
    wnp_position #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .block_width  (block_width_reg),
        .block_height (block_height_reg),
        .col          (col),
        .info         (info)
    );

    // Line store holding the previous row, read as a residual is accepted.
    wnp_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data)
    );

    // Prediction and reconstruction.
    wnp_predict #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_predict (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (residual_valid),
        .in_ready         (residual_ready),
        .residual         (residual),
        .info             (info),
        .col              (col),
        .accept           (accept),
        .weight_west      (weight_west_reg),
        .weight_north     (weight_north_reg),
        .weight_northwest (weight_northwest_reg),
        .rd_data          (rd_data),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .out_valid        (pixel_valid),
        .out_ready        (pixel_ready),
        .pixel_value      (pixel_value),
        .last_of_block    (last_of_block)
    );

endmodule

@@ bench/wnp_pixel_checker.sv @@
`timescale 1ns / 1ps
// Pixel checker for the weighted neighbor prediction decoder testbench.
// Watches the register, residual and pixel channels, predicts each pixel and compares.
// Depends on wnp_pkg for widths, register indexes, reset values and predictor modes.
module wnp_pixel_checker #(
    parameter int MAX_WIDTH = wnp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wnp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wnp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                residual_valid,
    input  logic                                residual_ready,
    input  logic signed [wnp_pkg::PIX_W-1:0]    residual,
    input  logic                                pixel_valid,
    input  logic                                pixel_ready,
    input  logic signed [wnp_pkg::PIX_W-1:0]    pixel_value,
    input  logic                                last_of_block,
    output int                                  mismatch_count,
    output int                                  results_pending,
    output logic                                at_block_start,
    output int                                  written_span,
    output int                                  block_ends
);
    import wnp_pkg::*;

    localparam int SHOW_LIMIT = 30;

    // One rebuilt pixel as the decoder should present it.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             ends_block;
    } pixel_beat_t;

    pixel_beat_t pixels_due[$];

    // Predictor state, kept apart from the block under test.
    logic signed [PIX_W-1:0]    row_above [MAX_WIDTH];
    logic signed [PIX_W-1:0]    west_pix;
    logic signed [PIX_W-1:0]    northwest_pix;
    int unsigned                col_pos;
    int unsigned                row_pos;
    int                         span;
    logic signed [WEIGHT_W-1:0] wt_west;
    logic signed [WEIGHT_W-1:0] wt_north;
    logic signed [WEIGHT_W-1:0] wt_northwest;
    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;
    int                         errors;
    int                         ends_seen;
    int                         shown;

    // A zero size counts as one; anything past the ceiling counts as the ceiling.
    function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] v,
                                                input int unsigned ceiling);
        if (v == 0)
            return 1;
        if (v > ceiling)
            return ceiling;
        return v;
    endfunction

    // Rebuild one pixel from its residual and advance the raster position.
    function automatic pixel_beat_t rebuild_pixel(input logic [PIX_W-1:0] res);
        int unsigned             w_eff;
        int unsigned             h_eff;
        int unsigned             idx;
        logic signed [PIX_W-1:0] above;
        logic signed [PIX_W-1:0] guess;
        longint                  acc;
        logic                    row_end;
        pred_mode_t              mode;
        pixel_beat_t             beat;
        w_eff = size_in_use(width_reg, MAX_WIDTH);
        h_eff = size_in_use(height_reg, HEIGHT_LIMIT);
        idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        above = row_above[idx];
        row_end = (col_pos + 1 >= w_eff);
        beat.ends_block = row_end && (row_pos + 1 >= h_eff);

        if (col_pos == 0 && row_pos == 0)
            mode = PRED_ZERO;
        else if (row_pos == 0)
            mode = PRED_WEST;
        else if (col_pos == 0)
            mode = PRED_NORTH;
        else
            mode = PRED_WEIGHTED;

        case (mode)
            PRED_ZERO:  guess = '0;
            PRED_WEST:  guess = west_pix;
            PRED_NORTH: guess = above;
            default:
            begin
                // Full-width products; the divide truncates toward zero.
                acc = longint'(wt_west) * longint'(west_pix)
                    + longint'(wt_north) * longint'(above)
                    + longint'(wt_northwest) * longint'(northwest_pix);
                acc = acc / (1 << FRAC_BITS);
                guess = acc[PIX_W-1:0];
            end
        endcase

        beat.value = guess + res;
        northwest_pix = above;
        row_above[idx] = beat.value;
        west_pix = beat.value;
        if (idx + 1 > span)
            span = idx + 1;

        if (beat.ends_block)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return beat;
    endfunction

    // Follow the channels at each edge; expectations are queued before results pop.
    always @(posedge clk)
    begin : watch
        pixel_beat_t due;
        if (!rst_n)
        begin
            pixels_due.delete();
            foreach (row_above[i])
                row_above[i] = '0;
            west_pix = '0;
            northwest_pix = '0;
            col_pos = 0;
            row_pos = 0;
            span = 0;
            wt_west = WEIGHT_WEST_RESET;
            wt_north = WEIGHT_NORTH_RESET;
            wt_northwest = WEIGHT_NORTHWEST_RESET;
            width_reg = BLOCK_WIDTH_RESET;
            height_reg = BLOCK_HEIGHT_RESET;
            errors = 0;
            ends_seen = 0;
            shown = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_WEIGHT_WEST:      wt_west = cfg_data;
                    REG_WEIGHT_NORTH:     wt_north = cfg_data;
                    REG_WEIGHT_NORTHWEST: wt_northwest = cfg_data;
                    REG_BLOCK_WIDTH:      width_reg = cfg_data[SIZE_W-1:0];
                    REG_BLOCK_HEIGHT:     height_reg = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (residual_valid && residual_ready)
                pixels_due.push_back(rebuild_pixel(residual));

            if (pixel_valid && pixel_ready)
            begin
                if (last_of_block === 1'b1)
                    ends_seen++;
                if (pixels_due.size() == 0)
                begin
                    errors++;
                    if (shown++ < SHOW_LIMIT)
                        $display("%0t: unexpected pixel beat, expected none, actual %h last %b",
                                 $time, pixel_value, last_of_block);
                end
                else
                begin
                    due = pixels_due.pop_front();
                    if (pixel_value !== due.value)
                    begin
                        errors++;
                        if (shown++ < SHOW_LIMIT)
                            $display("%0t: pixel_value mismatch, expected %h, actual %h",
                                     $time, due.value, pixel_value);
                    end
                    if (last_of_block !== due.ends_block)
                    begin
                        errors++;
                        if (shown++ < SHOW_LIMIT)
                            $display("%0t: last_of_block mismatch, expected %b, actual %b",
                                     $time, due.ends_block, last_of_block);
                    end
                end
            end
        end

        // Status for the stimulus side, updated after the edge to keep reads race free.
        mismatch_count <= errors;
        results_pending <= pixels_due.size();
        at_block_start <= (col_pos == 0 && row_pos == 0);
        written_span <= span;
        block_ends <= ends_seen;
    end

endmodule

@@ bench/tb_weighted_neighbor_prediction_decode_core.sv @@
`timescale 1ns / 1ps
// Testbench top for weighted_neighbor_prediction_decode_core: stimulus, stalls and verdict.
// Depends on wnp_pkg, the decoder RTL and wnp_pixel_checker, which predicts and compares.
module tb_weighted_neighbor_prediction_decode_core;
    import wnp_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    residual_valid = 1'b0;
    logic signed [PIX_W-1:0] residual = '0;
    logic                    pixel_ready = 1'b0;
    logic                    cfg_ready;
    logic                    residual_ready;
    logic                    pixel_valid;
    logic signed [PIX_W-1:0] pixel_value;
    logic                    last_of_block;

    int   mismatch_count;
    int   results_pending;
    logic at_block_start;
    int   written_span;
    int   block_ends;

    int                items_sent = 0;
    int                writes_done = 0;
    int                setting_changes = 0;
    int                burst_left = 0;
    int                cycle_count;
    logic [SIZE_W-1:0] cur_width = BLOCK_WIDTH_RESET;
    logic [SIZE_W-1:0] cur_height = BLOCK_HEIGHT_RESET;

    weighted_neighbor_prediction_decode_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .residual_valid (residual_valid),
        .residual_ready (residual_ready),
        .residual       (residual),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_value    (pixel_value),
        .last_of_block  (last_of_block)
    );

    wnp_pixel_checker #(
        .MAX_WIDTH (MAX_WIDTH_DEFAULT)
    ) pixel_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .residual_valid  (residual_valid),
        .residual_ready  (residual_ready),
        .residual        (residual),
        .pixel_valid     (pixel_valid),
        .pixel_ready     (pixel_ready),
        .pixel_value     (pixel_value),
        .last_of_block   (last_of_block),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .at_block_start  (at_block_start),
        .written_span    (written_span),
        .block_ends      (block_ends)
    );

    // 2 ns clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Pixel receiver: each stretch picks a stall style, from never stalling to mostly stalled.
    int stall_style = 0;
    int stretch_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stall_style <= $urandom_range(0, 4);
                stretch_left <= $urandom_range(16, 96);
            end
            else
            begin
                stretch_left <= stretch_left - 1;
            end
            case (stall_style)
                0:       pixel_ready <= 1'b1;
                1:       pixel_ready <= ($urandom_range(0, 3) != 0);
                2:       pixel_ready <= 1'($urandom_range(0, 1));
                3:       pixel_ready <= ($urandom_range(0, 7) == 0);
                default: pixel_ready <= ~pixel_ready;
            endcase
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Timed out after %0d cycles with %0d pixels outstanding",
                 cycle_count, results_pending);
        $display("[weighted_neighbor_prediction_decode_core] ERROR");
        $finish;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WIDTH_DEFAULT)
            return MAX_WIDTH_DEFAULT;
        return v;
    endfunction

    // Residuals: mostly small, some full range, some at the extremes.
    function automatic logic [PIX_W-1:0] pick_residual();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 1023) - 512;
        endcase
    endfunction

    // Weights: mostly near unity, sometimes extreme or fully random.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return WEIGHT_W'($urandom);
            default: return WEIGHT_W'($urandom_range(0, 512) - 256);
        endcase
    endfunction

    // Sizes: mostly small, now and then zero, large or past the ceiling.
    function automatic logic [SIZE_W-1:0] pick_size(input int common_max);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(MAX_WIDTH_DEFAULT + 1, (1 << SIZE_W) - 1));
            2:       return SIZE_W'($urandom_range(common_max + 1, MAX_WIDTH_DEFAULT));
            default: return SIZE_W'($urandom_range(1, common_max));
        endcase
    endfunction

    // Register write; valid is left high so back-to-back writes need no drop.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        writes_done++;
        if (idx == REG_BLOCK_WIDTH)
            cur_width = val[SIZE_W-1:0];
        if (idx == REG_BLOCK_HEIGHT)
            cur_height = val[SIZE_W-1:0];
    endtask

    // One residual beat, sent in bursts with random gaps between them.
    task automatic push_residual(input logic [PIX_W-1:0] value);
        int gap;
        // The register channel is closed once residuals flow.
        cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                residual_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        residual_valid <= 1'b1;
        residual <= value;
        do @(posedge clk); while (!residual_ready);
        burst_left--;
        items_sent++;
    endtask

    // Close the residual channel and wait until every pixel has come back.
    task automatic finish_phase();
        residual_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        setting_changes++;
    endtask

    initial
    begin : stimulus
        int               random_goal;
        int               n;
        logic [SIZE_W-1:0] w_try;
        logic [SIZE_W-1:0] h_try;
        logic [2:0]        pad;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 block with extreme weights and extreme residuals on every predictor.
        write_reg(REG_WEIGHT_WEST, 16'h7FFF);
        write_reg(REG_WEIGHT_NORTH, 16'h8000);
        write_reg(REG_WEIGHT_NORTHWEST, 16'hFFFF);
        write_reg(REG_BLOCK_WIDTH, 16'd3);
        write_reg(REG_BLOCK_HEIGHT, 16'd3);
        push_residual(32'h7FFF_FFFF);
        push_residual(32'h8000_0000);
        push_residual(32'h0000_0001);
        push_residual(32'hFFFF_FFFF);
        push_residual(32'h7FFF_FFFF);
        push_residual(32'h8000_0000);
        push_residual(32'h0000_0000);
        push_residual(32'h1234_5678);
        push_residual(32'hEDCB_A987);
        finish_phase();

        // Zero sizes count as one: every pixel is a whole block. Upper data bits are ignored.
        write_reg(REG_BLOCK_WIDTH, 16'hE000);
        write_reg(REG_BLOCK_HEIGHT, 16'h0000);
        push_residual(32'h5555_5555);
        push_residual(32'hAAAA_AAAA);
        finish_phase();

        // Largest width and height, default weights; stop partway along the top row.
        write_reg(REG_WEIGHT_WEST, WEIGHT_WEST_RESET);
        write_reg(REG_WEIGHT_NORTH, WEIGHT_NORTH_RESET);
        write_reg(REG_WEIGHT_NORTHWEST, WEIGHT_NORTHWEST_RESET);
        write_reg(REG_BLOCK_WIDTH, 16'hF000);
        write_reg(REG_BLOCK_HEIGHT, 16'h1000);
        push_residual(32'd10);
        push_residual(-32'sd3);
        push_residual(32'd7);
        push_residual(32'h0000_0100);
        finish_phase();

        // Shrink mid-block so the column already lies past the new width.
        write_reg(REG_BLOCK_WIDTH, 16'd2);
        write_reg(REG_BLOCK_HEIGHT, 16'd2);
        push_residual(32'd5);
        push_residual(32'hFFFF_FFF0);
        push_residual(32'h4000_0000);
        finish_phase();

        // Single column with a height past the ceiling, then a height below the current row.
        write_reg(REG_BLOCK_WIDTH, 16'd1);
        write_reg(REG_BLOCK_HEIGHT, 16'hFFFF);
        push_residual(32'd1);
        push_residual(32'd2);
        push_residual(32'd3);
        push_residual(32'd4);
        finish_phase();
        write_reg(REG_BLOCK_HEIGHT, 16'd2);
        push_residual(32'h8000_0000);
        push_residual(32'h7FFF_FFFF);
        finish_phase();

        // Random phases: new settings, then whole or partial blocks.
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            if ($urandom_range(0, 1))
                write_reg(REG_WEIGHT_WEST, pick_weight());
            if ($urandom_range(0, 1))
                write_reg(REG_WEIGHT_NORTH, pick_weight());
            if ($urandom_range(0, 1))
                write_reg(REG_WEIGHT_NORTHWEST, pick_weight());
            if ($urandom_range(0, 2) == 0)
            begin
                // Mid-block the width may grow only over line store entries already written.
                w_try = pick_size(12);
                if (!at_block_start && eff_size(w_try) > written_span)
                    w_try = SIZE_W'(written_span);
                pad = 3'($urandom);
                write_reg(REG_BLOCK_WIDTH, {pad, w_try});
            end
            if ($urandom_range(0, 2) == 0)
            begin
                h_try = pick_size(6);
                pad = 3'($urandom);
                write_reg(REG_BLOCK_HEIGHT, {pad, h_try});
            end

            n = eff_size(cur_width) * eff_size(cur_height);
            if (n > 64)
                n = $urandom_range(1, 40);
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            else
                n = n * $urandom_range(1, 3);
            repeat (n)
                push_residual(pick_residual());
            finish_phase();
        end

        // Let any stray beat show up before the verdict.
        repeat (8) @(posedge clk);

        $display("Run covered %0d residuals over %0d setting changes (%0d register writes).",
                 items_sent, setting_changes, writes_done);
        $display("Blocks closed: %0d; mismatches found: %0d.", block_ends, mismatch_count);
        if (mismatch_count == 0)
            $display("[weighted_neighbor_prediction_decode_core] OK");
        else
            $display("[weighted_neighbor_prediction_decode_core] ERROR");
        $finish;
    end

endmodule
